/* hw/rtl/rbu_pkg.sv */
// rbu_pkg: shared constants, types and helper functions of the rtc to unix time converter
package rbu_pkg;

    // subsecond counter width that is taken from the reading
    localparam int SUBSECOND_BITS = 15;

    // configuration port
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_PRESCALER    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEZONE_OFFSET_S = 1'b1;
    localparam logic [14:0] PRESCALER_RESET = 15'd255;

    // time constants
    localparam logic [29:0] EPOCH_2000_S    = 30'd946684800;
    localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
    localparam logic [11:0] SECONDS_PER_HR  = 12'd3600;
    localparam logic [5:0]  SECONDS_PER_MIN = 6'd60;
    localparam logic [9:0]  MS_PER_SECOND   = 10'd1000;
    localparam logic [9:0]  SAT_FRAC_MS     = 10'd999;

    // pipeline shape: register stages inside the datapath units
    localparam int PIPE_STAGES = 7;
    localparam int QUOT_W      = 10;
    localparam int DIV_STAGES  = QUOT_W / 2;

    // calendar path result at the last datapath stage
    typedef struct packed {
        logic [31:0] sec;
        logic [41:0] millis_base;
        logic        sat;
        logic        neg;
    } cal_res_t;

    // two bcd digits to binary, the tens nibble weighted by ten as it stands
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        return 8'({v[7:4], 3'b000}) + 8'({v[7:4], 1'b0}) + 8'(v[3:0]);
    endfunction

    // days before month idx+1 in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] idx);
        logic [8:0] d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

/* hw/rtl/rbu_reading_if.sv */
// rbu_reading_if: input channel carrying one bcd clock reading per transfer
interface rbu_reading_if;
    logic        valid;
    logic        ready;
    logic [7:0]  year_bcd;
    logic [4:0]  month_bcd;
    logic [5:0]  day_bcd;
    logic [5:0]  hour_bcd;
    logic [6:0]  minute_bcd;
    logic [6:0]  second_bcd;
    logic [14:0] subsecond_count;

    modport source (
        output valid, year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd,
               subsecond_count,
        input  ready
    );

    modport sink (
        input  valid, year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd, second_bcd,
               subsecond_count,
        output ready
    );
endinterface

/* hw/rtl/rbu_stamp_if.sv */
// rbu_stamp_if: output channel carrying one utc time stamp per transfer
interface rbu_stamp_if;
    logic        valid;
    logic        ready;
    logic [31:0] utc_seconds;
    logic [41:0] utc_millis;

    modport source (
        output valid, utc_seconds, utc_millis,
        input  ready
    );

    modport sink (
        input  valid, utc_seconds, utc_millis,
        output ready
    );
endinterface

/* hw/rtl/rbu_cal.sv */
// rbu_cal: seven-stage calendar path from bcd fields to utc seconds and the millisecond base
module rbu_cal (
    input  logic                 clk,
    input  logic                 advance,
    input  logic [7:0]           year_bcd,
    input  logic [4:0]           month_bcd,
    input  logic [5:0]           day_bcd,
    input  logic [5:0]           hour_bcd,
    input  logic [6:0]           minute_bcd,
    input  logic [6:0]           second_bcd,
    input  logic signed [16:0]   tz_offset,
    output rbu_pkg::cal_res_t    res
);
    import rbu_pkg::*;

    // stage 1: bcd decode
    logic [7:0] yr1_reg, yr1_next;
    logic [4:0] mon1_reg, mon1_next;
    logic [5:0] day1_reg, day1_next;
    logic [5:0] hr1_reg, hr1_next;
    logic [6:0] mn1_reg, mn1_next;
    logic [6:0] sc1_reg, sc1_next;

    // stage 2: days before the year and month, seconds of the day
    logic [15:0] ydays2_reg, ydays2_next;
    logic [8:0]  mdays2_reg, mdays2_next;
    logic [5:0]  day2_reg;
    logic [17:0] hms2_reg, hms2_next;
    logic [5:0]  leaps;
    logic [3:0]  mon_idx;
    logic        leap_yr;

    // stage 3: day count and constant seconds offset
    logic signed [16:0] days3_reg, days3_next;
    logic [29:0]        off3_reg, off3_next;

    // stage 4: day count in seconds
    logic [34:0] dsec4_reg, dsec4_next;
    logic [29:0] off4_reg;

    // stage 5: full signed utc sum
    logic [34:0] utc5_reg, utc5_next;

    // stage 6: clamp to 32 bits
    logic [31:0] sec6_reg, sec6_next;
    logic        sat6_reg, sat6_next;
    logic        neg6_reg, neg6_next;

    // stage 7: seconds scaled to milliseconds
    logic [31:0] sec7_reg;
    logic [41:0] base7_reg, base7_next;
    logic        sat7_reg;
    logic        neg7_reg;

    // bcd to binary
    always_comb
    begin
        yr1_next  = bcd_to_bin(year_bcd);
        mon1_next = 5'(bcd_to_bin(8'(month_bcd)));
        day1_next = 6'(bcd_to_bin(8'(day_bcd)));
        hr1_next  = 6'(bcd_to_bin(8'(hour_bcd)));
        mn1_next  = 7'(bcd_to_bin(8'(minute_bcd)));
        sc1_next  = 7'(bcd_to_bin(8'(second_bcd)));
    end

    // whole years since 2000 with leap days, month table, seconds of the day
    always_comb
    begin
        // leap years in 2000 .. 2000+yr-1; 2100 is the only century year that drops out
        leaps = 6'((9'(yr1_reg) + 9'd3) >> 2) - 6'(yr1_reg > 8'd100);
        ydays2_next = 16'(yr1_reg) * 16'd365 + 16'(leaps);

        // month zero counts as january, months past december as the whole year
        priority if (mon1_reg == 5'd0)
            mon_idx = 4'd0;
        else if (mon1_reg > 5'd13)
            mon_idx = 4'd12;
        else
            mon_idx = 4'(mon1_reg - 5'd1);

        leap_yr     = (yr1_reg[1:0] == 2'b00) && (yr1_reg != 8'd100);
        mdays2_next = cum_days(mon_idx) + 9'(leap_yr && (mon_idx >= 4'd2));

        hms2_next = 18'(hr1_reg) * 18'(SECONDS_PER_HR) + 18'(mn1_reg) * 18'(SECONDS_PER_MIN)
                  + 18'(sc1_reg);
    end

    // day count may reach minus one for day zero of january 2000
    always_comb
    begin
        days3_next = signed'(17'(ydays2_reg) + 17'(mdays2_reg) + 17'(day2_reg) - 17'd1);
        off3_next  = EPOCH_2000_S + 30'(hms2_reg) - 30'(tz_offset);
    end

    // days times seconds per day, sign kept in 35 bits
    assign dsec4_next = 35'(days3_reg) * 35'(SECONDS_PER_DAY);

    // offset is always positive and below 2^30
    assign utc5_next = dsec4_reg + 35'(off4_reg);

    // clamp: negative to zero, above 32 bits to all ones
    always_comb
    begin
        neg6_next = utc5_reg[34];
        sat6_next = !utc5_reg[34] && (utc5_reg[33:32] != 2'b00);
        priority if (neg6_next)
            sec6_next = '0;
        else if (sat6_next)
            sec6_next = '1;
        else
            sec6_next = utc5_reg[31:0];
    end

    assign base7_next = 42'(sec6_reg) * 42'(MS_PER_SECOND);

    // pipeline registers, frozen on a stall
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            yr1_reg    <= yr1_next;
            mon1_reg   <= mon1_next;
            day1_reg   <= day1_next;
            hr1_reg    <= hr1_next;
            mn1_reg    <= mn1_next;
            sc1_reg    <= sc1_next;

            ydays2_reg <= ydays2_next;
            mdays2_reg <= mdays2_next;
            day2_reg   <= day1_reg;
            hms2_reg   <= hms2_next;

            days3_reg  <= days3_next;
            off3_reg   <= off3_next;

            dsec4_reg  <= dsec4_next;
            off4_reg   <= off3_reg;

            utc5_reg   <= utc5_next;

            sec6_reg   <= sec6_next;
            sat6_reg   <= sat6_next;
            neg6_reg   <= neg6_next;

            sec7_reg   <= sec6_reg;
            base7_reg  <= base7_next;
            sat7_reg   <= sat6_reg;
            neg7_reg   <= neg6_reg;
        end
    end

    always_comb
    begin
        res.sec         = sec7_reg;
        res.millis_base = base7_reg;
        res.sat         = sat7_reg;
        res.neg         = neg7_reg;
    end

endmodule

/* hw/rtl/rbu_frac.sv */
// rbu_frac: seven-stage millisecond fraction path with a pipelined restoring divider
module rbu_frac (
    input  logic                       clk,
    input  logic                       advance,
    input  logic [14:0]                subsecond_count,
    input  logic [14:0]                prescaler,
    output logic [rbu_pkg::QUOT_W-1:0] frac_ms
);
    import rbu_pkg::*;

    // stage 1: elapsed ticks and divisor
    logic [14:0] ssr;
    logic [14:0] diff1_reg, diff1_next;
    logic [15:0] d1_reg;

    // stage 2: dividend
    logic [24:0] n2_reg, n2_next;
    logic [15:0] d2_reg;

    // divider stages, two quotient bits each
    logic [24:0]       rem_in [DIV_STAGES];
    logic [QUOT_W-1:0] q_in   [DIV_STAGES];
    logic [15:0]       d_in   [DIV_STAGES];
    logic [24:0]       rem_reg [DIV_STAGES-1];
    logic [15:0]       d_reg   [DIV_STAGES-1];
    logic [QUOT_W-1:0] q_reg   [DIV_STAGES];

    // a count above the prescaler gives zero elapsed ticks
    always_comb
    begin
        ssr        = 15'(subsecond_count[SUBSECOND_BITS-1:0]);
        diff1_next = (ssr <= prescaler) ? (prescaler - ssr) : '0;
    end

    assign n2_next = 25'(diff1_reg) * 25'(MS_PER_SECOND);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff1_reg <= diff1_next;
            d1_reg    <= 16'(prescaler) + 16'd1;
            n2_reg    <= n2_next;
            d2_reg    <= d1_reg;
        end
    end

    // quotient stays below 2^QUOT_W since the elapsed ticks stay below the divisor
    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        localparam int KHI = QUOT_W - 1 - 2 * s;
        localparam int KLO = KHI - 1;

        logic [25:0]       r_a;
        logic [25:0]       dsh_hi;
        logic [25:0]       dsh_lo;
        logic [QUOT_W-1:0] q_a;

        if (s == 0)
        begin : g_first
            assign rem_in[s] = n2_reg;
            assign q_in[s]   = '0;
            assign d_in[s]   = d2_reg;
        end
        else
        begin : g_next
            assign rem_in[s] = rem_reg[s-1];
            assign q_in[s]   = q_reg[s-1];
            assign d_in[s]   = d_reg[s-1];
        end

        // two compare and subtract steps
        always_comb
        begin
            dsh_hi = 26'(d_in[s]) << KHI;
            dsh_lo = 26'(d_in[s]) << KLO;
            r_a    = 26'(rem_in[s]);
            q_a    = q_in[s];
            if (r_a >= dsh_hi)
            begin
                r_a      = r_a - dsh_hi;
                q_a[KHI] = 1'b1;
            end
            if (r_a >= dsh_lo)
            begin
                r_a      = r_a - dsh_lo;
                q_a[KLO] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                q_reg[s] <= q_a;
            end
        end

        if (s < DIV_STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[s] <= 25'(r_a);
                    d_reg[s]   <= d_in[s];
                end
            end
        end
    end

    assign frac_ms = q_reg[DIV_STAGES-1];

endmodule

/* hw/rtl/rtc_bcd_to_unix_millis.sv */
// rtc_bcd_to_unix_millis: top level of the bcd clock reading to utc unix time converter
//
// Takes one bcd clock reading per transfer and returns the utc unix seconds and
// milliseconds for it, one result per reading, in order. A reading may enter in
// every cycle unless the pipeline holds; each result passes through seven datapath
// stages plus the output register. The depth is set by the millisecond divider,
// which resolves two quotient bits per stage over five stages after the multiply
// by 1000, with the calendar path cut to the same length around its
// multipliers. While a result waits in the output register the whole pipeline
// holds, and ready drops only then. Write the prescaler and timezone registers
// only while no reading is in flight.
module rtc_bcd_to_unix_millis (
    input  logic                             clk,
    input  logic                             rst_n,
    rbu_reading_if.sink                      reading,
    rbu_stamp_if.source                      stamp,
    input  logic                             cfg_write,
    input  logic [rbu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rbu_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rbu_pkg::*;

    logic [14:0]        prescaler_reg;
    logic signed [16:0] tz_offset_reg;

    logic                   advance;
    logic [PIPE_STAGES-1:0] valid_reg;
    logic                   out_valid_reg;
    logic [31:0]            utc_seconds_reg;
    logic [41:0]            utc_millis_reg, utc_millis_next;
    logic [9:0]             frac_sel;

    cal_res_t          cal_res;
    logic [QUOT_W-1:0] frac_ms;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescaler_reg <= PRESCALER_RESET;
            tz_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_PRESCALER:    prescaler_reg <= cfg_data[14:0];
                REG_TIMEZONE_OFFSET_S: tz_offset_reg <= signed'(cfg_data);
            endcase
        end
    end

    // pipeline moves whenever the output register is free or being emptied
    assign advance       = !out_valid_reg || stamp.ready;
    assign reading.ready = advance;

    rbu_cal u_cal (
        .clk        (clk),
        .advance    (advance),
        .year_bcd   (reading.year_bcd),
        .month_bcd  (reading.month_bcd),
        .day_bcd    (reading.day_bcd),
        .hour_bcd   (reading.hour_bcd),
        .minute_bcd (reading.minute_bcd),
        .second_bcd (reading.second_bcd),
        .tz_offset  (tz_offset_reg),
        .res        (cal_res)
    );

    rbu_frac u_frac (
        .clk             (clk),
        .advance         (advance),
        .subsecond_count (reading.subsecond_count),
        .prescaler       (prescaler_reg),
        .frac_ms         (frac_ms)
    );

    // valid bits alongside the datapath stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[PIPE_STAGES-2:0], reading.valid};
            out_valid_reg <= valid_reg[PIPE_STAGES-1];
        end
    end

    // saturated seconds carry 999 ms, a negative time carries nothing
    always_comb
    begin
        frac_sel = cal_res.sat ? SAT_FRAC_MS : 10'(frac_ms);
        utc_millis_next = cal_res.neg ? '0 : cal_res.millis_base + 42'(frac_sel);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            utc_seconds_reg <= cal_res.sec;
            utc_millis_reg  <= utc_millis_next;
        end
    end

    assign stamp.valid       = out_valid_reg;
    assign stamp.utc_seconds = utc_seconds_reg;
    assign stamp.utc_millis  = utc_millis_reg;

endmodule
